[sv/rpmg_pkg.sv]
// ----------------------------------------------------------------------------
// rpmg_pkg: shared types and constants of the Prim maze generator
// Grid bounds, queue sizing, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package rpmg_pkg;
  localparam int MAX_ROWS    = 32;
  localparam int MAX_COLS    = 32;
  localparam int QUEUE_DEPTH = 4096;
  localparam int NUM_CELLS   = MAX_ROWS * MAX_COLS;
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int COL_W       = $clog2(MAX_COLS);
  localparam int CELL_W      = ROW_W + COL_W;
  localparam int QADDR_W     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QADDR_W + 1;
  localparam int QENT_W      = CELL_W + 2;
  localparam int CELL_ENT_W  = 5;   // {taken, walls[3:0]}

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;
  localparam logic [1:0] REG_SROW = 2'd2;
  localparam logic [1:0] REG_SCOL = 2'd3;

  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CLEAR, ST_SEED, ST_DIV, ST_QRD, ST_QRD2, ST_QWAIT, ST_QMOVE,
    ST_RDA, ST_RDB, ST_CHK, ST_WRA, ST_WRB, ST_PUSH, ST_OUT
  } state_t;

  // last member sits in the lowest bits
  typedef struct packed {
    logic       finished;
    logic [4:0] end_col;
    logic [4:0] end_row;
    logic [1:0] direction;
    logic [4:0] cell_col;
    logic [4:0] cell_row;
    logic       wall_broken;
  } result_t;
endpackage

[sv/rpmg_ram.sv]
// ----------------------------------------------------------------------------
// rpmg_ram: generic single-port synchronous RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module rpmg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

[sv/rpmg_divider.sv]
// ----------------------------------------------------------------------------
// rpmg_divider: restoring remainder unit
// Produces num mod den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpmg_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [31:0]                 num,
  input  logic [rpmg_pkg::QCNT_W-1:0] den,
  output logic                        done,
  output logic [rpmg_pkg::QCNT_W-1:0] rem
);
  import rpmg_pkg::*;

  logic [31:0]       shreg;
  logic [QCNT_W:0]   part;
  logic [5:0]        cnt;
  logic              busy;
  logic [QCNT_W:0]   trial;

  always_comb trial = {part[QCNT_W-1:0], shreg[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= num;
      part  <= '0;
    end else if (busy) begin
      shreg <= {shreg[30:0], 1'b0};
      if (trial >= {1'b0, den}) part <= trial - {1'b0, den};
      else                      part <= trial;
    end
  end

  assign rem = part[QCNT_W-1:0];
endmodule

[sv/random_prim_maze_generator_core.sv]
// ----------------------------------------------------------------------------
// random_prim_maze_generator_core: randomized Prim maze generator
//
// Channel | Dir | Handshake            | Payload
// s_axis  | in  | tvalid/tready        | tuser=opcode, tdata=rand_value
// m_axis  | out | tvalid/tready        | tdata = result fields
// cfg     | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// Start item: a clearing sweep of the cell memory, one entry a cycle, then
// seeding and pushes, before the result is valid. Step item: a run of the
// remainder unit, then serial read-modify-writes on the cell and queue
// memories and up to four pushes; on an empty queue the item goes straight
// to the output. One item at a time; the output register frees the input
// while a result waits, and an untaken result holds the next in its final
// state. Reset is synchronous; there is no clearing pass after reset, since
// every cell starts walled and untaken through a reset-cleared "grid valid"
// flag.
// ----------------------------------------------------------------------------
module random_prim_maze_generator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // rand_value[31:0]
  input  logic        s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // wall_broken, cell_row[5], cell_col[5],
                                      // direction[2], end_row[5], end_col[5],
                                      // finished
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);
  import rpmg_pkg::*;

  state_t state, state_next;

  logic [5:0] grid_rows, grid_cols;
  logic [4:0] start_row, start_col;
  logic [5:0] eff_rows, eff_cols;

  logic [QCNT_W-1:0]  queue_count;
  logic [CELL_W-1:0]  end_point;
  logic               grid_valid;   // low: cell memory content counts as reset

  logic [CELL_W-1:0]  clr_addr;
  logic [QADDR_W-1:0] pick;
  logic [QENT_W-1:0]  ent;
  logic [QENT_W-1:0]  last_ent;
  logic [ROW_W-1:0]   ra, rb;
  logic [COL_W-1:0]   ca, cb;
  logic [1:0]         dir;
  logic               nb_ok;
  logic [CELL_ENT_W-1:0] cell_a, cell_b;
  logic               take_a, take_b;
  logic [ROW_W-1:0]   pr;
  logic [COL_W-1:0]   pc;
  logic [2:0]         pdir;
  logic               brk;
  logic [4:0]         brk_row, brk_col;
  logic [1:0]         brk_dir;
  logic               out_free;
  result_t            res;

  // memories
  logic                  c_we;
  logic [CELL_W-1:0]     c_addr;
  logic [CELL_ENT_W-1:0] c_wdata, c_rdata, c_rd;
  logic                  q_we;
  logic [QADDR_W-1:0]    q_addr;
  logic [QENT_W-1:0]     q_wdata, q_rdata;

  rpmg_ram #(.WIDTH(CELL_ENT_W), .DEPTH(NUM_CELLS)) u_cells (
    .clk(clk), .we(c_we), .addr(c_addr), .wdata(c_wdata), .rdata(c_rdata));
  rpmg_ram #(.WIDTH(QENT_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .we(q_we), .addr(q_addr), .wdata(q_wdata), .rdata(q_rdata));

  assign c_rd = grid_valid ? c_rdata : 5'b01111;

  logic              div_start, div_done;
  logic [QCNT_W-1:0] div_rem;
  rpmg_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(s_axis_tdata), .den(queue_count),
    .done(div_done), .rem(div_rem));

  always_comb begin
    eff_rows = (grid_rows == 6'd0) ? 6'd1 : (grid_rows > 6'(MAX_ROWS) ? 6'(MAX_ROWS) : grid_rows);
    eff_cols = (grid_cols == 6'd0) ? 6'd1 : (grid_cols > 6'(MAX_COLS) ? 6'(MAX_COLS) : grid_cols);
  end

  // neighbour of the push cell on side pdir exists and the queue has room
  logic push_ok;
  always_comb begin
    case (pdir[1:0])
      DIR_LEFT:  push_ok = pc != '0;
      DIR_RIGHT: push_ok = ({1'b0, pc} + 6'd1) < eff_cols;
      DIR_UP:    push_ok = pr != '0;
      default:   push_ok = ({1'b0, pr} + 6'd1) < eff_rows;
    endcase
    if (queue_count >= QCNT_W'(QUEUE_DEPTH)) push_ok = 1'b0;
  end

  // neighbour of the dequeued wall
  always_comb begin
    rb = ra;
    cb = ca;
    nb_ok = ({1'b0, ra} < eff_rows) && ({1'b0, ca} < eff_cols);
    case (dir)
      DIR_LEFT:  begin nb_ok = nb_ok && ca != '0; cb = ca - 1'b1; end
      DIR_RIGHT: begin nb_ok = nb_ok && ({1'b0, ca} + 6'd1) < eff_cols; cb = ca + 1'b1; end
      DIR_UP:    begin nb_ok = nb_ok && ra != '0; rb = ra - 1'b1; end
      default:   begin nb_ok = nb_ok && ({1'b0, ra} + 6'd1) < eff_rows; rb = ra + 1'b1; end
    endcase
  end

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tdata  = res;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == OP_START) state_next = ST_CLEAR;
        else if (queue_count == '0)   state_next = ST_OUT;
        else                          state_next = ST_DIV;
      end
      ST_CLEAR: if (clr_addr == CELL_W'(NUM_CELLS - 1)) state_next = ST_SEED;
      ST_SEED:  state_next = ST_PUSH;
      ST_DIV:   if (div_done) state_next = ST_QRD;
      ST_QRD:   state_next = ST_QRD2;
      ST_QRD2:  state_next = ST_QWAIT;
      ST_QWAIT: state_next = ST_QMOVE;
      ST_QMOVE: state_next = nb_ok ? ST_RDA : ST_OUT;
      ST_RDA:   state_next = ST_RDB;
      ST_RDB:   state_next = ST_CHK;
      ST_CHK:   state_next = (c_rd[4] && cell_a[4]) ? ST_OUT : ST_WRA;
      ST_WRA:   state_next = ST_WRB;
      ST_WRB:   state_next = ST_PUSH;
      ST_PUSH:  if (pdir == 3'd4) state_next = ST_OUT;
      ST_OUT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    c_we = 1'b0; c_addr = {ra, ca}; c_wdata = '0;
    q_we = 1'b0; q_addr = pick; q_wdata = last_ent;
    div_start = 1'b0;
    case (state)
      ST_IDLE:  div_start = s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_STEP
                            && queue_count != '0;
      ST_CLEAR: begin c_we = 1'b1; c_addr = clr_addr; c_wdata = 5'b01111; end
      ST_SEED:  begin c_we = 1'b1; c_addr = {pr, pc}; c_wdata = 5'b11111; end
      ST_QRD:   q_addr = pick;
      ST_QRD2:  q_addr = QADDR_W'(queue_count - 1'b1);
      ST_QMOVE: begin q_we = 1'b1; q_addr = pick; end
      ST_RDA:   c_addr = {ra, ca};
      ST_RDB:   c_addr = {rb, cb};
      ST_WRA:   begin c_we = 1'b1; c_addr = {ra, ca};
                  c_wdata = {1'b1, cell_a[3:0] & ~(4'b1 << dir)}; end
      ST_WRB:   begin c_we = 1'b1; c_addr = {rb, cb};
                  c_wdata = {1'b1, cell_b[3:0] & ~(4'b1 << (dir ^ 2'd1))}; end
      ST_PUSH:  begin q_we = push_ok && pdir != 3'd4; q_addr = queue_count[QADDR_W-1:0];
                  q_wdata = {pr, pc, pdir[1:0]}; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      grid_rows <= 6'd32; grid_cols <= 6'd32; start_row <= '0; start_col <= '0;
      queue_count <= '0; end_point <= '0; grid_valid <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROWS: grid_rows <= cfg_data;
          REG_COLS: grid_cols <= cfg_data;
          REG_SROW: start_row <= cfg_data[4:0];
          REG_SCOL: start_col <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (state == ST_OUT && out_free) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready)          m_axis_tvalid <= 1'b0;
      case (state)
        ST_CLEAR: if (clr_addr == CELL_W'(NUM_CELLS - 1)) grid_valid <= 1'b1;
        ST_SEED:  begin queue_count <= '0; end_point <= {pr, pc}; end
        ST_QMOVE: queue_count <= queue_count - 1'b1;
        ST_WRA:   if (take_a) end_point <= {ra, ca};
        ST_WRB:   if (take_b) end_point <= {rb, cb};
        ST_PUSH:  if (q_we) queue_count <= queue_count + 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        clr_addr <= '0;
        if (s_axis_tvalid && s_axis_tready) begin
          brk <= 1'b0; brk_row <= '0; brk_col <= '0; brk_dir <= '0;
        end
      end
      ST_CLEAR: begin
        clr_addr <= clr_addr + 1'b1;
        pr <= ({1'b0, start_row} >= eff_rows) ? ROW_W'(eff_rows - 6'd1) : start_row;
        pc <= ({1'b0, start_col} >= eff_cols) ? COL_W'(eff_cols - 6'd1) : start_col;
        pdir <= '0;
      end
      ST_DIV: if (div_done) pick <= div_rem[QADDR_W-1:0];
      ST_QRD2: ent <= q_rdata;
      ST_QWAIT: begin
        last_ent <= q_rdata;
        ra <= ent[QENT_W-1 -: ROW_W];
        ca <= ent[2 +: COL_W];
        dir <= ent[1:0];
      end
      ST_RDB: cell_a <= c_rd;
      ST_CHK: begin
        cell_b <= c_rd;
        take_a <= !cell_a[4];
        take_b <= !c_rd[4];
      end
      ST_WRA: if (take_a) begin pr <= ra; pc <= ca; pdir <= '0; end
      ST_WRB: begin
        if (!take_a) begin pr <= rb; pc <= cb; pdir <= '0; end
        brk <= 1'b1; brk_row <= 5'(ra); brk_col <= 5'(ca);
        brk_dir <= dir;
      end
      ST_PUSH: if (pdir != 3'd4) pdir <= pdir + 3'd1;
      ST_OUT: if (out_free) begin
        res.wall_broken <= brk;
        res.cell_row <= brk_row;
        res.cell_col <= brk_col;
        res.direction <= brk_dir;
        res.end_row <= 5'(end_point[CELL_W-1 -: ROW_W]);
        res.end_col <= 5'(end_point[COL_W-1:0]);
        res.finished <= queue_count == '0;
      end
      default: ;
    endcase
  end
endmodule

[sv/rpmg_checker.sv]
// ----------------------------------------------------------------------------
// rpmg_checker: port-level checks of the maze generator
// Watches the stream ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
module rpmg_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed while stalled");
  a_in_then_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken back to back");
  a_no_wall_fields: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[12:1] == 12'd0)
    else $error("wall fields set on an item with no broken wall");
  a_valid_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown(m_axis_tvalid))
    else $error("result valid unknown");
endmodule

bind random_prim_maze_generator_core rpmg_checker u_rpmg_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata));
